>>> src/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/tods_pkg.sv
// Shared constants, types and helper functions of the schedule duty block.
`timescale 1ns / 1ps
package tods_pkg;

    localparam int SLOT_COUNT    = 6;
    localparam int ENTRY_W       = 26;
    localparam int HOUR_W        = 5;
    localparam int MIN_W         = 6;
    localparam int DUTY_W        = 7;
    localparam int LEVEL_W       = 8;
    localparam int TIME_W        = 11;
    localparam int COUNT_W       = 3;
    localparam int MOD_W         = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = ENTRY_W;

    localparam int HOUR_LSB      = 0;
    localparam int MIN_LSB       = 5;
    localparam int DUTY_LSB      = 11;
    localparam int LEVEL_LSB     = 18;

    localparam int MIN_PER_HOUR  = 60;
    localparam int BLOCK_MIN     = 20;
    localparam int PERCENT_FULL  = 100;
    // floor(20 * d / 100) = floor(d / 5), exact for d <= 100 as (d * 205) >> 10.
    localparam int DIV5_MUL      = 205;
    localparam int DIV5_SHIFT    = 10;
    localparam int PROD_W        = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_FIRST = 3'd1;

    typedef struct packed {
        logic [COUNT_W-1:0]                    count;
        logic [SLOT_COUNT-1:0][ENTRY_W-1:0]    entry;
    } t_cfg;

    typedef struct packed {
        logic               found;
        logic [TIME_W-1:0]  time_m;
        logic [DUTY_W-1:0]  duty;
        logic [LEVEL_W-1:0] level;
    } t_cand;

    function automatic logic [TIME_W-1:0] entry_time(input logic [ENTRY_W-1:0] e);
        return TIME_W'(e[HOUR_LSB +: HOUR_W]) * TIME_W'(MIN_PER_HOUR)
             + TIME_W'(e[MIN_LSB +: MIN_W]);
    endfunction

    // b is the higher-index candidate, so it wins ties.
    function automatic t_cand pick_later(input t_cand a, input t_cand b);
        if (b.found && (!a.found || b.time_m >= a.time_m)) begin
            return b;
        end
        return a;
    endfunction

    // A 6-bit minute can reach 63, so up to three blocks may need to come off.
    function automatic logic [MOD_W-1:0] mod_block(input logic [MIN_W-1:0] m);
        logic [MIN_W-1:0] r;
        r = m;
        if (r >= MIN_W'(3 * BLOCK_MIN)) begin
            r = r - MIN_W'(3 * BLOCK_MIN);
        end else if (r >= MIN_W'(2 * BLOCK_MIN)) begin
            r = r - MIN_W'(2 * BLOCK_MIN);
        end else if (r >= MIN_W'(BLOCK_MIN)) begin
            r = r - MIN_W'(BLOCK_MIN);
        end
        return r[MOD_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] duty_sat(input logic [DUTY_W-1:0] d);
        return (d > DUTY_W'(PERCENT_FULL)) ? DUTY_W'(PERCENT_FULL) : d;
    endfunction

    function automatic logic [MOD_W-1:0] duty_threshold(input logic [DUTY_W-1:0] d);
        logic [PROD_W-1:0] p;
        p = PROD_W'(d) * PROD_W'(DIV5_MUL);
        return p[DIV5_SHIFT +: MOD_W];
    endfunction

endpackage

>>> src/time_of_day_schedule_duty.sv
// Top level of the time-of-day schedule duty block.
//
//   channel  direction  handshake                    payload
//   in       input      i_in_valid / o_in_ready      i_hour_now, i_minute_now
//   out      output     o_out_valid / i_out_ready    o_enable_out, o_level_out, o_duty_out
//   cfg      input      i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// One transaction per cycle while the output is not stalled; each result passes through
// the four register stages (time, pair select, final select, output) before it is on
// the outputs.
// Synchronous active-low reset clears all stage valid bits and the configuration.
// A stall on the output backs up stage by stage; each stage holds its data until taken.
`timescale 1ns / 1ps
module time_of_day_schedule_duty (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tods_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tods_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [tods_pkg::HOUR_W-1:0]       i_hour_now,
    input  logic [tods_pkg::MIN_W-1:0]        i_minute_now,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_enable_out,
    output logic [tods_pkg::LEVEL_W-1:0]      o_level_out,
    output logic [tods_pkg::DUTY_W-1:0]       o_duty_out
);

    tods_pkg::t_cfg                   cfg;

    logic                             s1_valid;
    logic                             s1_ready;
    logic [tods_pkg::TIME_W-1:0]      s1_now;
    logic [tods_pkg::MOD_W-1:0]       s1_mod;

    logic                             s3_valid;
    logic                             s3_ready;
    logic [tods_pkg::DUTY_W-1:0]      s3_duty;
    logic [tods_pkg::LEVEL_W-1:0]     s3_level;
    logic [tods_pkg::MOD_W-1:0]       s3_mod;

    tods_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tods_time u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_hour   (i_hour_now),
        .i_minute (i_minute_now),
        .o_valid  (s1_valid),
        .i_ready  (s1_ready),
        .o_now    (s1_now),
        .o_mod    (s1_mod)
    );

    tods_pick u_pick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (s1_valid),
        .o_ready  (s1_ready),
        .i_now    (s1_now),
        .i_mod    (s1_mod),
        .o_valid  (s3_valid),
        .i_ready  (s3_ready),
        .o_duty   (s3_duty),
        .o_level  (s3_level),
        .o_mod    (s3_mod)
    );

    tods_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s3_valid),
        .o_ready  (s3_ready),
        .i_duty   (s3_duty),
        .i_level  (s3_level),
        .i_mod    (s3_mod),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_enable (o_enable_out),
        .o_level  (o_level_out),
        .o_duty   (o_duty_out)
    );

endmodule

>>> src/tods_regs.sv
// Configuration registers: entry count and the six schedule entries.
`timescale 1ns / 1ps
module tods_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tods_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tods_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output tods_pkg::t_cfg                    o_cfg
);

    logic [tods_pkg::COUNT_W-1:0]                                 r_count;
    logic [tods_pkg::SLOT_COUNT-1:0][tods_pkg::ENTRY_W-1:0]       r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we && i_cfg_idx == tods_pkg::CFG_COUNT) begin
            r_count <= i_cfg_data[tods_pkg::COUNT_W-1:0];
        end
    end

    // Indexes past the last entry match no slot and are dropped.
    for (genvar k = 0; k < tods_pkg::SLOT_COUNT; k++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_entry[k] <= '0;
            end else if (i_cfg_we && i_cfg_idx ==
                         tods_pkg::CFG_ENTRY_FIRST + tods_pkg::CFG_IDX_W'(k)) begin
                r_entry[k] <= i_cfg_data[tods_pkg::ENTRY_W-1:0];
            end
        end
    end

    assign o_cfg.count = r_count;
    assign o_cfg.entry = r_entry;

endmodule

>>> src/tods_time.sv
// First stage: minutes since midnight and minute position in the 20-minute block.
`timescale 1ns / 1ps
module tods_time (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tods_pkg::HOUR_W-1:0]    i_hour,
    input  logic [tods_pkg::MIN_W-1:0]     i_minute,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tods_pkg::TIME_W-1:0]    o_now,
    output logic [tods_pkg::MOD_W-1:0]     o_mod
);

    logic                          r_valid;
    logic [tods_pkg::TIME_W-1:0]   r_now;
    logic [tods_pkg::MOD_W-1:0]    r_mod;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_now <= tods_pkg::TIME_W'(i_hour) * tods_pkg::TIME_W'(tods_pkg::MIN_PER_HOUR)
                   + tods_pkg::TIME_W'(i_minute);
            r_mod <= tods_pkg::mod_block(i_minute);
        end
    end

    assign o_valid = r_valid;
    assign o_now   = r_now;
    assign o_mod   = r_mod;

endmodule

>>> src/tods_pick.sv
// Two stages that select the latest qualifying entry: pairwise, then final.
`timescale 1ns / 1ps
module tods_pick (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tods_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tods_pkg::TIME_W-1:0]    i_now,
    input  logic [tods_pkg::MOD_W-1:0]     i_mod,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tods_pkg::DUTY_W-1:0]    o_duty,
    output logic [tods_pkg::LEVEL_W-1:0]   o_level,
    output logic [tods_pkg::MOD_W-1:0]     o_mod
);

    localparam int PAIRS = tods_pkg::SLOT_COUNT / 2;

    tods_pkg::t_cand                       cand [tods_pkg::SLOT_COUNT];
    tods_pkg::t_cand                       pair [PAIRS];
    tods_pkg::t_cand                       best;

    logic                                  r_s2_valid;
    tods_pkg::t_cand                       r_s2_pair [PAIRS];
    logic [tods_pkg::MOD_W-1:0]            r_s2_mod;
    logic                                  s2_ready;

    logic                                  r_s3_valid;
    logic [tods_pkg::DUTY_W-1:0]           r_s3_duty;
    logic [tods_pkg::LEVEL_W-1:0]          r_s3_level;
    logic [tods_pkg::MOD_W-1:0]            r_s3_mod;
    logic                                  s3_ready;

    always_comb begin
        for (int k = 0; k < tods_pkg::SLOT_COUNT; k++) begin
            cand[k].time_m = tods_pkg::entry_time(i_cfg.entry[k]);
            cand[k].found  = (tods_pkg::COUNT_W'(k) < i_cfg.count) && (cand[k].time_m <= i_now);
            cand[k].duty   = i_cfg.entry[k][tods_pkg::DUTY_LSB +: tods_pkg::DUTY_W];
            cand[k].level  = i_cfg.entry[k][tods_pkg::LEVEL_LSB +: tods_pkg::LEVEL_W];
        end
        for (int p = 0; p < PAIRS; p++) begin
            pair[p] = tods_pkg::pick_later(cand[2 * p], cand[2 * p + 1]);
        end
    end

    assign s3_ready = !r_s3_valid || i_ready;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign o_ready  = s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_valid <= i_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_s2_pair <= pair;
            r_s2_mod  <= i_mod;
        end
    end

    always_comb begin
        best = r_s2_pair[0];
        for (int p = 1; p < PAIRS; p++) begin
            best = tods_pkg::pick_later(best, r_s2_pair[p]);
        end
    end

    // With no qualifying entry both duty and level read as zero.
    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_valid) begin
            r_s3_duty  <= best.found ? tods_pkg::duty_sat(best.duty) : '0;
            r_s3_level <= best.found ? best.level : '0;
            r_s3_mod   <= r_s2_mod;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_duty  = r_s3_duty;
    assign o_level = r_s3_level;
    assign o_mod   = r_s3_mod;

endmodule

>>> src/tods_out.sv
// Output stage: enable threshold compare and the result register.
`timescale 1ns / 1ps
module tods_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tods_pkg::DUTY_W-1:0]    i_duty,
    input  logic [tods_pkg::LEVEL_W-1:0]   i_level,
    input  logic [tods_pkg::MOD_W-1:0]     i_mod,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_enable,
    output logic [tods_pkg::LEVEL_W-1:0]   o_level,
    output logic [tods_pkg::DUTY_W-1:0]    o_duty
);

    logic                           r_valid;
    logic                           r_enable;
    logic [tods_pkg::LEVEL_W-1:0]   r_level;
    logic [tods_pkg::DUTY_W-1:0]    r_duty;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_enable <= i_mod < tods_pkg::duty_threshold(i_duty);
            r_level  <= i_level;
            r_duty   <= i_duty;
        end
    end

    assign o_valid  = r_valid;
    assign o_enable = r_enable;
    assign o_level  = r_level;
    assign o_duty   = r_duty;

endmodule

>>> src/tods_checker.sv
// Port-level checker for the schedule duty block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tods_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tods_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tods_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic [tods_pkg::HOUR_W-1:0]       i_hour_now,
    input  logic [tods_pkg::MIN_W-1:0]        i_minute_now,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic                              o_enable_out,
    input  logic [tods_pkg::LEVEL_W-1:0]      o_level_out,
    input  logic [tods_pkg::DUTY_W-1:0]       o_duty_out
);

    // Reset empties the pipeline, so no result may show in the next cycle.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    `ASSERT_CLK(a_duty_range, i_clk, i_rst_n, o_out_valid |-> o_duty_out <= tods_pkg::DUTY_W'(tods_pkg::PERCENT_FULL), "duty above full scale")

    // The enable window is empty when duty is zero.
    `ASSERT_CLK(a_enable_duty, i_clk, i_rst_n, o_out_valid && o_enable_out |-> o_duty_out != '0, "enable set with zero duty")

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_enable_out) && $stable(o_level_out) && $stable(o_duty_out), "stalled transaction changed")

endmodule

bind time_of_day_schedule_duty tods_checker u_tods_checker (.*);

>>> test/schedule_duty_checker.sv
// Checker that predicts and compares every result of the schedule duty block.
`timescale 1ns / 1ps
module schedule_duty_checker
    import tods_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [HOUR_W-1:0]     i_hour_now,
    input  logic [MIN_W-1:0]      i_minute_now,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_enable_out,
    input  logic [LEVEL_W-1:0]    i_level_out,
    input  logic [DUTY_W-1:0]     i_duty_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic               enable;
        logic [LEVEL_W-1:0] level;
        logic [DUTY_W-1:0]  duty;
    } duty_result_t;

    logic [COUNT_W-1:0] sched_count;
    logic [ENTRY_W-1:0] sched_entry [SLOT_COUNT];
    duty_result_t       duty_expect_q [$];
    int                 fail_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_cnt     = 0;
        sched_count  = '0;
        foreach (sched_entry[i]) sched_entry[i] = '0;
    end

    // Latest entry whose time is not after now; a later index wins a tie.
    function automatic duty_result_t schedule_lookup(input logic [HOUR_W-1:0] hour,
                                                     input logic [MIN_W-1:0]  minute);
        int           now_min;
        int           slot_min;
        int           best_min;
        int           used;
        int           duty;
        bit           hit;
        logic [ENTRY_W-1:0] best;
        duty_result_t res;
        now_min  = int'(hour) * MIN_PER_HOUR + int'(minute);
        used     = (int'(sched_count) > SLOT_COUNT) ? SLOT_COUNT : int'(sched_count);
        hit      = 1'b0;
        best_min = 0;
        best     = '0;
        for (int i = 0; i < used; i++) begin
            slot_min = int'(sched_entry[i][HOUR_LSB +: HOUR_W]) * MIN_PER_HOUR
                     + int'(sched_entry[i][MIN_LSB +: MIN_W]);
            if (slot_min <= now_min && (!hit || slot_min >= best_min)) begin
                hit      = 1'b1;
                best_min = slot_min;
                best     = sched_entry[i];
            end
        end
        duty      = hit ? int'(best[DUTY_LSB +: DUTY_W]) : 0;
        if (duty > PERCENT_FULL) begin
            duty = PERCENT_FULL;
        end
        res.level  = hit ? best[LEVEL_LSB +: LEVEL_W] : '0;
        res.duty   = DUTY_W'(duty);
        res.enable = (int'(minute) % BLOCK_MIN) < (BLOCK_MIN * duty / PERCENT_FULL);
        return res;
    endfunction

    always @(posedge i_clk) begin
        duty_result_t want;
        if (!i_rst_n) begin
            sched_count = '0;
            foreach (sched_entry[i]) sched_entry[i] = '0;
            duty_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COUNT) begin
                    sched_count = i_cfg_data[COUNT_W-1:0];
                end else if (int'(i_cfg_idx) >= int'(CFG_ENTRY_FIRST) &&
                             int'(i_cfg_idx) < int'(CFG_ENTRY_FIRST) + SLOT_COUNT) begin
                    sched_entry[int'(i_cfg_idx) - int'(CFG_ENTRY_FIRST)] =
                        i_cfg_data[ENTRY_W-1:0];
                end
            end
            // Results are retired before new inputs are queued, so a result can never
            // be matched to a transaction taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (duty_expect_q.size() == 0) begin
                    if (fail_cnt < REPORT_MAX) begin
                        $display("%0t: result with nothing expected: en=%0b level=%0d duty=%0d",
                                 $time, i_enable_out, i_level_out, i_duty_out);
                    end
                    fail_cnt++;
                end else begin
                    want = duty_expect_q.pop_front();
                    if (i_enable_out !== want.enable || i_level_out !== want.level ||
                        i_duty_out !== want.duty) begin
                        if (fail_cnt < REPORT_MAX) begin
                            $display("%0t: mismatch: expected en=%0b level=%0d duty=%0d, got en=%0b level=%0d duty=%0d",
                                     $time, want.enable, want.level, want.duty,
                                     i_enable_out, i_level_out, i_duty_out);
                        end
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                duty_expect_q.push_back(schedule_lookup(i_hour_now, i_minute_now));
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= duty_expect_q.size();
    end

endmodule

>>> test/time_of_day_schedule_duty_test.sv
// Stimulus and verdict for the time-of-day schedule duty block.
`timescale 1ns / 1ps
module time_of_day_schedule_duty_test;
    import tods_pkg::*;

    localparam int MAX_GAP       = 8;
    localparam int PHASE_ITEMS   = 155;
    localparam int PHASE_COUNT   = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(int'(CFG_ENTRY_FIRST) + SLOT_COUNT);

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZERO} fill_style_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [HOUR_W-1:0]     hour_now   = '0;
    logic [MIN_W-1:0]      minute_now = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic                  enable_out;
    logic [LEVEL_W-1:0]    level_out;
    logic [DUTY_W-1:0]     duty_out;
    int                    fail_count;
    int                    pending;
    int                    cycle_cnt  = 0;
    bit                    quiet      = 1'b0;
    bit                    hold_req   = 1'b0;

    time_of_day_schedule_duty u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_hour_now   (hour_now),
        .i_minute_now (minute_now),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_enable_out (enable_out),
        .o_level_out  (level_out),
        .o_duty_out   (duty_out)
    );

    schedule_duty_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_hour_now   (hour_now),
        .i_minute_now (minute_now),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_enable_out (enable_out),
        .i_level_out  (level_out),
        .i_duty_out   (duty_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: a random wait before each result outside quiet phases, and one long hold-off on request.
    initial begin
        int rx_gap;
        rx_gap = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_gap > 0) begin
                out_ready <= 1'b0;
                repeat (rx_gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            rx_gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    function automatic logic [ENTRY_W-1:0] pack_entry(input logic [HOUR_W-1:0]  hour,
                                                      input logic [MIN_W-1:0]   minute,
                                                      input logic [DUTY_W-1:0]  duty,
                                                      input logic [LEVEL_W-1:0] level);
        return {level, duty, minute, hour};
    endfunction

    function automatic logic [ENTRY_W-1:0] random_entry();
        logic [DUTY_W-1:0] duty;
        if ($urandom_range(0, 7) == 0) begin
            return ENTRY_W'($urandom);
        end
        duty = ($urandom_range(0, 4) == 0) ? DUTY_W'($urandom_range(101, 127))
                                           : DUTY_W'($urandom_range(0, 100));
        return pack_entry(HOUR_W'($urandom_range(0, 23)), MIN_W'($urandom_range(0, 59)),
                          duty, LEVEL_W'($urandom));
    endfunction

    task automatic send_update(input logic [HOUR_W-1:0] hour, input logic [MIN_W-1:0] minute);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        hour_now   <= hour;
        minute_now <= minute;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
    endtask

    task automatic send_random_update();
        if ($urandom_range(0, 6) == 0) begin
            send_update(HOUR_W'($urandom), MIN_W'($urandom));
        end else begin
            send_update(HOUR_W'($urandom_range(0, 23)), MIN_W'($urandom_range(0, 59)));
        end
    endtask

    // Stop offering, wait until every expected result is out, then let the pipeline settle.
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_schedule(input logic [COUNT_W-1:0] count_val,
                                 input logic [ENTRY_W-1:0] slot [SLOT_COUNT]);
        write_reg(CFG_COUNT, CFG_DATA_W'(count_val));
        for (int i = 0; i < SLOT_COUNT; i++) begin
            write_reg(CFG_IDX_W'(int'(CFG_ENTRY_FIRST) + i), CFG_DATA_W'(slot[i]));
        end
        // The spare index must be ignored by the block.
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic load_generated(input logic [COUNT_W-1:0] count_val, input fill_style_t style);
        logic [ENTRY_W-1:0] slot [SLOT_COUNT];
        for (int i = 0; i < SLOT_COUNT; i++) begin
            case (style)
                FILL_ONES: begin
                    slot[i] = '1;
                end
                FILL_ZERO: begin
                    slot[i] = '0;
                end
                default: begin
                    slot[i] = random_entry();
                    // Now and then reuse the previous time so that ties get exercised.
                    if (i > 0 && $urandom_range(0, 3) == 0) begin
                        slot[i][MIN_LSB+MIN_W-1:HOUR_LSB] = slot[i-1][MIN_LSB+MIN_W-1:HOUR_LSB];
                    end
                end
            endcase
        end
        load_schedule(count_val, slot);
    endtask

    initial begin
        logic [ENTRY_W-1:0] slot [SLOT_COUNT];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset configuration no entry is in use.
        send_update(HOUR_W'(0), MIN_W'(0));
        send_update(HOUR_W'(23), MIN_W'(59));
        drain(SETTLE_CYCLES);

        // Hand-built schedule: a tie at 6:30, saturated duty, zero threshold,
        // an entry beyond the day, and a count above the number of slots.
        slot[0] = pack_entry(HOUR_W'(1),  MIN_W'(0),  DUTY_W'(100), LEVEL_W'(255));
        slot[1] = pack_entry(HOUR_W'(6),  MIN_W'(30), DUTY_W'(127), LEVEL_W'(1));
        slot[2] = pack_entry(HOUR_W'(6),  MIN_W'(30), DUTY_W'(50),  LEVEL_W'(2));
        slot[3] = pack_entry(HOUR_W'(12), MIN_W'(0),  DUTY_W'(4),   LEVEL_W'(3));
        slot[4] = pack_entry(HOUR_W'(31), MIN_W'(63), DUTY_W'(5),   LEVEL_W'(4));
        slot[5] = pack_entry(HOUR_W'(18), MIN_W'(0),  DUTY_W'(99),  LEVEL_W'(128));
        load_schedule(COUNT_W'(7), slot);
        send_update(HOUR_W'(0),  MIN_W'(0));
        send_update(HOUR_W'(0),  MIN_W'(59));
        send_update(HOUR_W'(0),  MIN_W'(63));
        send_update(HOUR_W'(1),  MIN_W'(0));
        send_update(HOUR_W'(1),  MIN_W'(19));
        send_update(HOUR_W'(6),  MIN_W'(29));
        send_update(HOUR_W'(6),  MIN_W'(30));
        send_update(HOUR_W'(6),  MIN_W'(39));
        send_update(HOUR_W'(6),  MIN_W'(40));
        send_update(HOUR_W'(12), MIN_W'(0));
        send_update(HOUR_W'(17), MIN_W'(59));
        send_update(HOUR_W'(18), MIN_W'(0));
        send_update(HOUR_W'(18), MIN_W'(19));
        send_update(HOUR_W'(23), MIN_W'(59));
        send_update(HOUR_W'(24), MIN_W'(0));
        send_update(HOUR_W'(31), MIN_W'(60));
        send_update(HOUR_W'(31), MIN_W'(62));
        send_update(HOUR_W'(31), MIN_W'(63));
        drain(SETTLE_CYCLES);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            quiet = 1'b0;
            case (phase)
                0: load_generated(COUNT_W'(6), FILL_RANDOM);
                1: begin
                    quiet = 1'b1;
                    load_generated(COUNT_W'(7), FILL_RANDOM);
                end
                2: load_generated(COUNT_W'(0), FILL_RANDOM);
                3: load_generated(COUNT_W'(6), FILL_ONES);
                4: load_generated(COUNT_W'(6), FILL_ZERO);
                5: load_generated(COUNT_W'(1), FILL_RANDOM);
                6: begin
                    // Back-to-back input against a stalled output fills the pipeline.
                    quiet    = 1'b1;
                    hold_req = 1'b1;
                    load_generated(COUNT_W'(6), FILL_RANDOM);
                end
                default: load_generated(COUNT_W'($urandom_range(0, 7)), FILL_RANDOM);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_update();
            end
            drain(SETTLE_CYCLES);
        end

        drain(4 * SETTLE_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
